// ----- rtl/rme_pkg.sv -----
// ----------------------------------------------------------------------------
// rme_pkg: shared definitions for the register machine executor
// Word and address widths, opcodes and the divider request and response types.
// ----------------------------------------------------------------------------
package rme_pkg;

    localparam int DATA_DEPTH = 1024;
    localparam int PROG_DEPTH = 1024;
    localparam int REG_COUNT  = 8;
    localparam int WORD_WIDTH = 32;
    localparam int PC_INDEX   = 7;

    // fixed field widths of the instruction and result transactions
    localparam int MODE_W = 5;
    localparam int BASE_W = 10;
    localparam int NUM_W  = 32;

    localparam int ADDR_W = $clog2(DATA_DEPTH);
    localparam int PC_W   = $clog2(PROG_DEPTH);
    localparam int REG_W  = $clog2(REG_COUNT);
    localparam int CNT_W  = $clog2(WORD_WIDTH);

    typedef logic [WORD_WIDTH-1:0] t_word;
    typedef logic [ADDR_W-1:0]     t_addr;
    typedef logic [MODE_W-1:0]     t_mode;

    localparam t_mode OP_IN   = MODE_W'(0);
    localparam t_mode OP_OUT  = MODE_W'(1);
    localparam t_mode OP_ADD  = MODE_W'(2);
    localparam t_mode OP_SUB  = MODE_W'(3);
    localparam t_mode OP_MUL  = MODE_W'(4);
    localparam t_mode OP_DIV  = MODE_W'(5);
    localparam t_mode OP_LD   = MODE_W'(6);
    localparam t_mode OP_ST   = MODE_W'(7);
    localparam t_mode OP_LDA  = MODE_W'(8);
    localparam t_mode OP_LDC  = MODE_W'(9);
    localparam t_mode OP_JMP  = MODE_W'(10);
    localparam t_mode OP_JLT  = MODE_W'(11);
    localparam t_mode OP_JLE  = MODE_W'(12);
    localparam t_mode OP_JGT  = MODE_W'(13);
    localparam t_mode OP_JGE  = MODE_W'(14);
    localparam t_mode OP_JEQ  = MODE_W'(15);
    localparam t_mode OP_JNE  = MODE_W'(16);
    localparam t_mode OP_HALT = MODE_W'(17);

    typedef struct packed {
        logic  start;
        t_word dividend;
        t_word divisor;
    } t_div_req;

    typedef struct packed {
        logic  done;
        t_word quotient;
    } t_div_rsp;

endpackage

// ----- rtl/rme_if.sv -----
// ----------------------------------------------------------------------------
// rme_if: instruction and result channels
// Valid/ready channels; a transaction moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface rme_in_if import rme_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [MODE_W-1:0]       mode;
    logic [REG_W-1:0]        target_reg;
    logic [BASE_W-1:0]       mem_base;
    logic signed [NUM_W-1:0] operand_num;
    logic                    indexed;
    logic signed [NUM_W-1:0] in_value;

    modport source (output valid, mode, target_reg, mem_base, operand_num, indexed,
                    in_value, input ready);
    modport sink   (input valid, mode, target_reg, mem_base, operand_num, indexed,
                    in_value, output ready);
endinterface

interface rme_out_if import rme_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [PC_W-1:0]         next_pc;
    logic                    out_valid;
    logic signed [NUM_W-1:0] out_value;
    logic                    halted;
    logic                    div_zero;

    modport source (output valid, next_pc, out_valid, out_value, halted, div_zero,
                    input ready);
    modport sink   (input valid, next_pc, out_valid, out_value, halted, div_zero,
                    output ready);
endinterface

// ----- rtl/rme_div.sv -----
// ----------------------------------------------------------------------------
// rme_div: iterative signed divider
// Restoring division on magnitudes, one quotient bit per cycle, truncating.
// ----------------------------------------------------------------------------
module rme_div import rme_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic             r_busy;
    logic             r_done;
    logic             r_neg;
    logic [CNT_W-1:0] r_cnt;
    t_word            r_rem;
    t_word            r_quo;
    t_word            r_den;
    t_word            r_q_out;

    t_word             w_a_mag;
    t_word             w_b_mag;
    logic [WORD_WIDTH:0] w_shift;
    logic [WORD_WIDTH:0] w_diff;
    logic              w_fit;
    t_word             w_quo_next;
    t_word             w_rem_next;
    t_word             w_quo_signed;

    always_comb begin
        w_a_mag = i_req.dividend[WORD_WIDTH-1] ? (t_word'(0) - i_req.dividend)
                                               : i_req.dividend;
        w_b_mag = i_req.divisor[WORD_WIDTH-1] ? (t_word'(0) - i_req.divisor)
                                              : i_req.divisor;
        w_shift      = {r_rem, r_quo[WORD_WIDTH-1]};
        w_diff       = w_shift - {1'b0, r_den};
        w_fit        = !w_diff[WORD_WIDTH];
        w_quo_next   = {r_quo[WORD_WIDTH-2:0], w_fit};
        w_rem_next   = w_fit ? w_diff[WORD_WIDTH-1:0] : w_shift[WORD_WIDTH-1:0];
        w_quo_signed = r_neg ? (t_word'(0) - w_quo_next) : w_quo_next;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_cnt <= CNT_W'(WORD_WIDTH - 1);
            r_rem <= '0;
            r_quo <= w_a_mag;
            r_den <= w_b_mag;
            r_neg <= i_req.dividend[WORD_WIDTH-1] ^ i_req.divisor[WORD_WIDTH-1];
        end else if (r_busy) begin
            r_cnt <= r_cnt - CNT_W'(1);
            r_rem <= w_rem_next;
            r_quo <= w_quo_next;
            if (r_cnt == '0) begin
                r_q_out <= w_quo_signed;
            end
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_q_out;

endmodule

// ----- rtl/register_machine_executor.sv -----
// ----------------------------------------------------------------------------
// register_machine_executor: single-step register machine
// Executes one fetched instruction per input transaction against eight
// registers (register 7 is the program counter) and a word data memory.
// ----------------------------------------------------------------------------
// Usage: after reset the block sweeps the data memory to zero, one word a
// cycle over all 1024 words, and takes no instruction until the sweep is done.
// Each instruction then produces exactly one result transaction. Every
// instruction runs an execute step and a finish step that registers its
// result; the data memory's single port and the bit-serial divider add steps
// between them: a load step for a direct load, an index step for an indexed
// store, an index then a load step for an indexed load (slot read, then data
// read), and a divide step for a divide with a nonzero divisor (32 quotient
// bits). The next instruction is accepted in the cycle that registers the
// result, so instructions never overlap. A result waiting on a stalled sink
// holds the finishing step until the output register frees up.
// ----------------------------------------------------------------------------
module register_machine_executor import rme_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rme_in_if.sink    i_in,
    rme_out_if.source o_out
);

    typedef enum logic [6:0] {
        S_CLEAR = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_EXEC  = 7'b0000100,
        S_IDX   = 7'b0001000,
        S_LOAD  = 7'b0010000,
        S_DIV   = 7'b0100000,
        S_FIN   = 7'b1000000
    } t_state;

    t_state r_state;
    t_state n_state;
    t_addr  r_clr_addr;

    // architectural state
    t_word r_regs [REG_COUNT];
    t_word r_mem  [DATA_DEPTH];
    t_word r_mem_rdata;

    // captured instruction
    t_mode                   r_mode;
    logic [REG_W-1:0]        r_treg;
    logic [BASE_W-1:0]       r_base;
    logic signed [NUM_W-1:0] r_num;
    logic                    r_idx;
    logic signed [NUM_W-1:0] r_inval;

    // pending write-back and result flags
    logic             r_wen;
    logic [REG_W-1:0] r_wsel;
    t_word            r_wval;
    logic             r_taken;
    logic             r_dz;
    logic             r_ov;
    logic             r_halt;
    logic [NUM_W-1:0] r_outv;

    // values the execute step loads into the pending registers
    logic             n_wen;
    logic [REG_W-1:0] n_wsel;
    t_word            n_wval;
    logic             n_dz;
    logic             n_ov;
    logic             n_halt;
    logic [NUM_W-1:0] n_outv;

    // output register
    logic             r_out_vld;
    logic [PC_W-1:0]  r_out_pc;
    logic             r_out_ov;
    logic [NUM_W-1:0] r_out_value;
    logic             r_out_halt;
    logic             r_out_dz;

    logic     w_slot_free;
    logic     w_accept;
    logic     w_taken;
    t_addr    w_direct_addr;
    t_addr    w_slot_addr;
    t_addr    w_idx_addr;
    t_addr    w_mem_addr;
    logic     w_mem_we;
    logic     w_mem_re;
    t_word    w_mem_wdata;
    t_word    w_pc_base;
    t_word    w_pc_after;
    logic     w_div_by_zero;
    t_word    w_prod;
    t_div_req w_div_req;
    t_div_rsp w_div_rsp;

    rme_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    // ------------------------------------------------------------------
    // Handshake: take a new instruction when idle, or in the same cycle the
    // previous one commits its result into a free output register.
    // ------------------------------------------------------------------
    assign w_slot_free = !r_out_vld || o_out.ready;
    assign i_in.ready  = (r_state == S_IDLE) || ((r_state == S_FIN) && w_slot_free);
    assign w_accept    = i_in.valid && i_in.ready;

    // ------------------------------------------------------------------
    // Address forms. Depths are powers of two, so wrapping a two's
    // complement sum into the memory is just its low bits.
    // ------------------------------------------------------------------
    assign w_slot_addr   = r_num[ADDR_W-1:0];
    assign w_direct_addr = t_addr'(r_base) + r_num[ADDR_W-1:0];
    assign w_idx_addr    = t_addr'(r_base) + r_mem_rdata[ADDR_W-1:0];

    assign w_div_by_zero = (r_regs[2] == '0);
    assign w_prod        = r_regs[1] * r_regs[2];

    // jump condition on register 0, signed against zero
    always_comb begin
        unique case (r_mode) inside
            OP_JMP:  w_taken = 1'b1;
            OP_JLT:  w_taken = $signed(r_regs[0]) < 0;
            OP_JLE:  w_taken = $signed(r_regs[0]) <= 0;
            OP_JGT:  w_taken = $signed(r_regs[0]) > 0;
            OP_JGE:  w_taken = $signed(r_regs[0]) >= 0;
            OP_JEQ:  w_taken = r_regs[0] == '0;
            OP_JNE:  w_taken = r_regs[0] != '0;
            default: w_taken = 1'b0;
        endcase
    end

    // ------------------------------------------------------------------
    // Data memory port. One instruction is in flight at a time and each
    // step of it touches the port at most once, so no two accesses ever overlap.
    // ------------------------------------------------------------------
    always_comb begin
        w_mem_we    = 1'b0;
        w_mem_re    = 1'b0;
        w_mem_addr  = w_direct_addr;
        w_mem_wdata = r_regs[r_treg];
        unique case (r_state)
            S_CLEAR: begin
                w_mem_we    = 1'b1;
                w_mem_addr  = r_clr_addr;
                w_mem_wdata = '0;
            end
            S_EXEC: begin
                if ((r_mode == OP_LD || r_mode == OP_ST) && r_idx) begin
                    w_mem_re   = 1'b1;
                    w_mem_addr = w_slot_addr;
                end else if (r_mode == OP_LD) begin
                    w_mem_re = 1'b1;
                end else if (r_mode == OP_ST) begin
                    w_mem_we = 1'b1;
                end
            end
            S_IDX: begin
                w_mem_addr = w_idx_addr;
                w_mem_re   = (r_mode == OP_LD);
                w_mem_we   = (r_mode == OP_ST);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[w_mem_addr] <= w_mem_wdata;
        end
        if (w_mem_re) begin
            r_mem_rdata <= r_mem[w_mem_addr];
        end
    end

    // start the divider only for a nonzero divisor; zero is settled at once
    assign w_div_req.start    = (r_state == S_EXEC) && (r_mode == OP_DIV) && !w_div_by_zero;
    assign w_div_req.dividend = r_regs[1];
    assign w_div_req.divisor  = r_regs[2];

    // ------------------------------------------------------------------
    // Program counter: a taken jump loads the sign-extended target; any
    // other instruction increments, after a write-back to register 7 if
    // there is one. Halt leaves it alone.
    // ------------------------------------------------------------------
    assign w_pc_base  = (r_wen && r_wsel == REG_W'(PC_INDEX)) ? r_wval : r_regs[PC_INDEX];
    assign w_pc_after = r_halt  ? r_regs[PC_INDEX] :
                        r_taken ? t_word'(r_num)   : (w_pc_base + t_word'(1));

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_clr_addr == t_addr'(DATA_DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                unique case (r_mode)
                    OP_DIV:  n_state = w_div_by_zero ? S_FIN : S_DIV;
                    OP_LD:   n_state = r_idx ? S_IDX : S_LOAD;
                    OP_ST:   n_state = r_idx ? S_IDX : S_FIN;
                    default: n_state = S_FIN;
                endcase
            end
            S_IDX:  n_state = (r_mode == OP_LD) ? S_LOAD : S_FIN;
            S_LOAD: n_state = S_FIN;
            S_DIV: begin
                if (w_div_rsp.done) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (w_slot_free) begin
                    n_state = w_accept ? S_EXEC : S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control state, register file and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_addr <= '0;
            r_out_vld  <= 1'b0;
            for (int i = 0; i < REG_COUNT; i++) begin
                r_regs[i] <= (i == PC_INDEX) ? t_word'(1) : t_word'(0);
            end
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr_addr <= r_clr_addr + t_addr'(1);
            end
            if (r_state == S_FIN && w_slot_free) begin
                // commit: write back any register but the counter, which
                // already folds in a write-back aimed at it
                if (r_wen && r_wsel != REG_W'(PC_INDEX)) begin
                    r_regs[r_wsel] <= r_wval;
                end
                r_regs[PC_INDEX] <= w_pc_after;
                r_out_vld        <= 1'b1;
            end else if (o_out.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // per-opcode write-back and result flags of the execute step
    always_comb begin
        n_wen  = 1'b0;
        n_wsel = '0;
        n_wval = '0;
        n_dz   = 1'b0;
        n_ov   = 1'b0;
        n_halt = 1'b0;
        n_outv = '0;
        unique case (r_mode) inside
            OP_IN: begin
                n_wen  = 1'b1;
                n_wval = t_word'(r_inval);
            end
            OP_OUT: begin
                n_ov   = 1'b1;
                n_outv = NUM_W'(r_regs[0]);
            end
            OP_ADD: begin
                n_wen  = 1'b1;
                n_wval = r_regs[1] + r_regs[2];
            end
            OP_SUB: begin
                n_wen  = 1'b1;
                n_wval = r_regs[1] - r_regs[2];
            end
            OP_MUL: begin
                n_wen  = 1'b1;
                n_wval = w_prod;
            end
            OP_DIV: begin
                // zero divisor: write 0 and flag it; else the divider fills in
                n_wen = 1'b1;
                n_dz  = w_div_by_zero;
            end
            OP_LD: begin
                n_wen  = 1'b1;
                n_wsel = r_treg;
            end
            OP_LDC: begin
                n_wen  = 1'b1;
                n_wsel = r_treg;
                n_wval = t_word'(r_num);
            end
            OP_HALT: begin
                n_halt = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // instruction capture and per-step results
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_mode  <= i_in.mode;
            r_treg  <= i_in.target_reg;
            r_base  <= i_in.mem_base;
            r_num   <= i_in.operand_num;
            r_idx   <= i_in.indexed;
            r_inval <= i_in.in_value;
        end
        unique case (r_state)
            S_EXEC: begin
                r_wen   <= n_wen;
                r_wsel  <= n_wsel;
                r_wval  <= n_wval;
                r_taken <= w_taken;
                r_dz    <= n_dz;
                r_ov    <= n_ov;
                r_halt  <= n_halt;
                r_outv  <= n_outv;
            end
            S_LOAD: begin
                r_wval <= r_mem_rdata;
            end
            S_DIV: begin
                if (w_div_rsp.done) begin
                    r_wval <= w_div_rsp.quotient;
                end
            end
            default: begin
            end
        endcase
        if (r_state == S_FIN && w_slot_free) begin
            r_out_pc    <= w_pc_after[PC_W-1:0];
            r_out_ov    <= r_ov;
            r_out_value <= r_outv;
            r_out_halt  <= r_halt;
            r_out_dz    <= r_dz;
        end
    end

    assign o_out.valid     = r_out_vld;
    assign o_out.next_pc   = r_out_pc;
    assign o_out.out_valid = r_out_ov;
    assign o_out.out_value = r_out_value;
    assign o_out.halted    = r_out_halt;
    assign o_out.div_zero  = r_out_dz;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_fin_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN && !w_slot_free) |=> (r_state == S_FIN))
        else $error("finish step left while the output register was busy");

    a_commit_sets_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN && w_slot_free) |=> r_out_vld)
        else $error("committed instruction produced no result transaction");

    a_div_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_req.start |=> (r_state == S_DIV))
        else $error("divider started outside a divide");

    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_rsp.done |-> (r_state == S_DIV))
        else $error("divider result arrived with no divide waiting");

    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |=> !(r_state == S_EXEC))
        else $error("instruction executed during the memory clear sweep");

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for register_machine_executor
// Drives single instructions over the input channel, predicts each result
// with a shadow register file and data memory, and compares every result
// transaction field by field. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
import rme_pkg::*;

typedef struct packed {
    t_mode              mode;
    logic [REG_W-1:0]   target_reg;
    logic [BASE_W-1:0]  mem_base;
    logic [NUM_W-1:0]   operand_num;
    logic               indexed;
    logic [NUM_W-1:0]   in_value;
} t_instr;

typedef struct packed {
    logic [PC_W-1:0]    next_pc;
    logic               out_valid;
    logic [NUM_W-1:0]   out_value;
    logic               halted;
    logic               div_zero;
} t_step_result;

class machine_scoreboard;
    localparam int MAX_REPORTS = 10;

    t_word        regs[REG_COUNT];
    t_word        dmem[DATA_DEPTH];
    t_step_result expected_q[$];

    int errors;
    int instr_count;
    int result_count;
    int div_zero_count;
    int jumps_taken;
    int halt_count;
    int out_count;

    function new();
        foreach (regs[r]) regs[r] = '0;
        foreach (dmem[a]) dmem[a] = '0;
        regs[PC_INDEX] = t_word'(1);
    endfunction

    // Depth is a power of two, so reducing any signed sum modulo depth keeps
    // the low address bits, negative sums included.
    function t_addr data_address(t_instr ins);
        t_addr off;
        if (ins.indexed) begin
            off = t_addr'(dmem[t_addr'(ins.operand_num)]);
        end else begin
            off = t_addr'(ins.operand_num);
        end
        return t_addr'(ins.mem_base + off);
    endfunction

    function t_step_result execute_step(t_instr ins);
        t_step_result                  res;
        t_word                         a;
        t_word                         b;
        logic signed [WORD_WIDTH-1:0]  r0;
        logic                          taken;
        res   = '0;
        a     = regs[1];
        b     = regs[2];
        r0    = regs[0];
        taken = 1'b0;
        case (ins.mode)
            OP_IN:  regs[0] = t_word'($signed(ins.in_value));
            OP_OUT: begin
                res.out_valid = 1'b1;
                res.out_value = regs[0][NUM_W-1:0];
                out_count++;
            end
            OP_ADD: regs[0] = a + b;
            OP_SUB: regs[0] = a - b;
            OP_MUL: regs[0] = a * b;
            OP_DIV: begin
                if (b == '0) begin
                    regs[0] = '0;
                    res.div_zero = 1'b1;
                    div_zero_count++;
                end else if (b == '1) begin
                    // most negative / -1 wraps back to itself
                    regs[0] = -a;
                end else begin
                    regs[0] = t_word'($signed(a) / $signed(b));
                end
            end
            OP_LD:  regs[ins.target_reg] = dmem[data_address(ins)];
            OP_ST:  dmem[data_address(ins)] = regs[ins.target_reg];
            OP_LDC: regs[ins.target_reg] = t_word'($signed(ins.operand_num));
            OP_JMP: taken = 1'b1;
            OP_JLT: taken = (r0 < 0);
            OP_JLE: taken = (r0 <= 0);
            OP_JGT: taken = (r0 > 0);
            OP_JGE: taken = (r0 >= 0);
            OP_JEQ: taken = (r0 == 0);
            OP_JNE: taken = (r0 != 0);
            OP_HALT: begin
                res.halted = 1'b1;
                halt_count++;
            end
            default: ;  // lda and unused codes only advance the counter
        endcase
        if (ins.mode != OP_HALT) begin
            if (taken) begin
                regs[PC_INDEX] = t_word'($signed(ins.operand_num));
                jumps_taken++;
            end else begin
                regs[PC_INDEX] = regs[PC_INDEX] + 1'b1;
            end
        end
        res.next_pc = regs[PC_INDEX][PC_W-1:0];
        return res;
    endfunction

    function void note_instr(t_instr ins);
        expected_q.push_back(execute_step(ins));
        instr_count++;
    endfunction

    function void compare_field(string field, logic [NUM_W-1:0] want, logic [NUM_W-1:0] got);
        if (got !== want) begin
            errors++;
            if (errors <= MAX_REPORTS) begin
                $display("ERROR: result %0d field %s: expected 0x%0h, got 0x%0h",
                         result_count, field, want, got);
            end
        end
    endfunction

    function void check_result(t_step_result got);
        t_step_result want;
        result_count++;
        if (expected_q.size() == 0) begin
            errors++;
            if (errors <= MAX_REPORTS) begin
                $display("ERROR: result %0d arrived with nothing expected: 0x%0h",
                         result_count, got);
            end
            return;
        end
        want = expected_q.pop_front();
        compare_field("next_pc",   NUM_W'(want.next_pc),   NUM_W'(got.next_pc));
        compare_field("out_valid", NUM_W'(want.out_valid), NUM_W'(got.out_valid));
        compare_field("out_value", want.out_value,         got.out_value);
        compare_field("halted",    NUM_W'(want.halted),    NUM_W'(got.halted));
        compare_field("div_zero",  NUM_W'(want.div_zero),  NUM_W'(got.div_zero));
    endfunction
endclass

module testbench;

    localparam int CLK_PERIOD    = 10;
    localparam int RESET_CYCLES  = 8;
    localparam int RANDOM_ITEMS  = 2000;
    localparam int IDLE_PERCENT  = 29;
    // stretch of transactions with no idling on either side
    localparam int QUIET_FIRST   = 1200;
    localparam int QUIET_LAST    = 1500;
    // long sink hold-off to back up the block and stall its input
    localparam int STALL_AT      = 500;
    localparam int STALL_CYCLES  = 400;
    // slowest op is a divide; leave a margin after the last result
    localparam int DRAIN_CYCLES  = 64;
    // memory sweep after reset, then worst case divides with long
    // random gaps on both sides, several times over
    localparam int CYCLE_LIMIT   = 400_000;
    localparam int UNUSED_CODES  = (2 ** MODE_W) - 1 - int'(OP_HALT);
    localparam int JUMP_CODES    = int'(OP_JNE) - int'(OP_JMP);

    logic i_clk = 1'b0;
    logic i_rst_n;
    int   cycle_count = 0;
    int   directed_count = 0;

    machine_scoreboard sb;

    rme_in_if  instr_ch ();
    rme_out_if result_ch ();

    register_machine_executor DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (instr_ch),
        .o_out   (result_ch)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Hard stop if the block hangs anywhere in the run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("ERROR: no progress within %0d cycles", CYCLE_LIMIT);
            $display("register_machine_executor test failed");
            $finish;
        end
    end

    function automatic t_instr make_instr(t_mode m, int treg, int base,
                                          logic [NUM_W-1:0] num, bit idx,
                                          logic [NUM_W-1:0] inval);
        t_instr ins;
        ins.mode        = m;
        ins.target_reg  = REG_W'(treg);
        ins.mem_base    = BASE_W'(base);
        ins.operand_num = num;
        ins.indexed     = idx;
        ins.in_value    = inval;
        return ins;
    endfunction

    // Mix edge words with small values so registers, slots and addresses
    // collide often, plus full-width noise to toggle every bit.
    function automatic logic [NUM_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return {1'b1, {(NUM_W-1){1'b0}}};
            1:       return {1'b0, {(NUM_W-1){1'b1}}};
            2:       return '1;
            3:       return '0;
            4, 5, 6: return NUM_W'($urandom_range(0, 15));
            7:       return NUM_W'(-int'($urandom_range(1, 16)));
            default: return NUM_W'($urandom());
        endcase
    endfunction

    function automatic t_instr random_instr();
        t_instr ins;
        int     pick;
        ins.target_reg  = REG_W'($urandom_range(0, REG_COUNT - 1));
        ins.operand_num = pick_value();
        ins.in_value    = pick_value();
        ins.indexed     = 1'($urandom_range(0, 1));
        // keep most bases low so loads see earlier stores; some near the top
        // so the sum wraps
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: ins.mem_base = BASE_W'($urandom_range(0, 15));
            6:                ins.mem_base = BASE_W'('1) - BASE_W'($urandom_range(0, 15));
            default:          ins.mem_base = BASE_W'($urandom());
        endcase
        pick = $urandom_range(0, 99);
        if      (pick < 8)  ins.mode = OP_IN;
        else if (pick < 14) ins.mode = OP_OUT;
        else if (pick < 22) ins.mode = OP_ADD;
        else if (pick < 28) ins.mode = OP_SUB;
        else if (pick < 34) ins.mode = OP_MUL;
        else if (pick < 40) ins.mode = OP_DIV;
        else if (pick < 52) ins.mode = OP_LD;
        else if (pick < 64) ins.mode = OP_ST;
        else if (pick < 67) ins.mode = OP_LDA;
        else if (pick < 79) ins.mode = OP_LDC;
        else if (pick < 93) ins.mode = t_mode'(int'(OP_JMP) + $urandom_range(0, JUMP_CODES));
        else if (pick < 96) ins.mode = OP_HALT;
        else                ins.mode = t_mode'(int'(OP_HALT) + $urandom_range(1, UNUSED_CODES));
        return ins;
    endfunction

    // Offer one instruction, optionally after random idle cycles, and hold
    // it until the block takes the transaction.
    task automatic send_instr(t_instr ins, bit may_idle);
        while (may_idle && $urandom_range(0, 99) < IDLE_PERCENT) begin
            instr_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        instr_ch.valid       <= 1'b1;
        instr_ch.mode        <= ins.mode;
        instr_ch.target_reg  <= ins.target_reg;
        instr_ch.mem_base    <= ins.mem_base;
        instr_ch.operand_num <= ins.operand_num;
        instr_ch.indexed     <= ins.indexed;
        instr_ch.in_value    <= ins.in_value;
        @(posedge i_clk);
        while (instr_ch.ready !== 1'b1) @(posedge i_clk);
        sb.note_instr(ins);
    endtask

    task automatic run_directed();
        t_instr q[$];
        // most negative word in and out
        q.push_back(make_instr(OP_IN,  0, 0, '0, 0, 32'h8000_0000));
        q.push_back(make_instr(OP_OUT, 0, 0, '0, 0, '0));
        // divide overflow, divide by zero, truncation toward zero
        q.push_back(make_instr(OP_LDC, 1, 0, 32'h8000_0000, 0, '0));
        q.push_back(make_instr(OP_LDC, 2, 0, 32'hFFFF_FFFF, 0, '0));
        q.push_back(make_instr(OP_DIV, 0, 0, '0, 0, '0));
        q.push_back(make_instr(OP_LDC, 2, 0, '0, 0, '0));
        q.push_back(make_instr(OP_DIV, 0, 0, '0, 0, '0));
        q.push_back(make_instr(OP_LDC, 2, 0, 32'd7, 0, '0));
        q.push_back(make_instr(OP_DIV, 0, 0, '0, 0, '0));
        q.push_back(make_instr(OP_SUB, 0, 0, '0, 0, '0));
        q.push_back(make_instr(OP_MUL, 0, 0, '0, 0, '0));
        q.push_back(make_instr(OP_ADD, 0, 0, '0, 0, '0));
        // base plus offset past the top wraps to 4; a negative offset reads it back
        q.push_back(make_instr(OP_ST, 1, 1023, 32'd5, 0, '0));
        q.push_back(make_instr(OP_LD, 3, 0, 32'hFFFF_FC04, 0, '0));
        // slot 4 holds the most negative word, so indexed lands on the base
        q.push_back(make_instr(OP_ST, 2, 1023, 32'd4, 1, '0));
        q.push_back(make_instr(OP_LD, 4, 1023, 32'h8000_0004, 1, '0));
        q.push_back(make_instr(OP_LDA, 0, 0, '0, 0, '0));
        // constant into the program counter, then it increments past the top
        q.push_back(make_instr(OP_LDC, PC_INDEX, 0, 32'h7FFF_FFFF, 0, '0));
        q.push_back(make_instr(OP_JGT, 0, 0, 32'd100, 0, '0));
        q.push_back(make_instr(OP_JLT, 0, 0, 32'hFFFF_FFFF, 0, '0));
        q.push_back(make_instr(OP_JLE, 0, 0, 32'd300, 0, '0));
        q.push_back(make_instr(OP_JGE, 0, 0, 32'd400, 0, '0));
        q.push_back(make_instr(OP_JEQ, 0, 0, 32'd500, 0, '0));
        q.push_back(make_instr(OP_JNE, 0, 0, 32'h8000_0200, 0, '0));
        q.push_back(make_instr(OP_JMP, 0, 0, 32'd1023, 0, '0));
        q.push_back(make_instr(OP_HALT, 0, 0, '0, 0, '0));
        q.push_back(make_instr(t_mode'(int'(OP_HALT) + 1), 0, 0, '0, 0, '0));
        q.push_back(make_instr(t_mode'('1), 0, 0, '0, 0, '0));
        foreach (q[k]) send_instr(q[k], 1'b1);
        directed_count = q.size();
    endtask

    // Result side: check every accepted transaction, then pick ready for the
    // next cycle; one long hold-off fills the block up.
    initial begin
        t_step_result got;
        int           results_seen;
        int           hold_left;
        bit           stall_done;
        results_seen = 0;
        hold_left    = 0;
        stall_done   = 1'b0;
        result_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
                got.next_pc   = result_ch.next_pc;
                got.out_valid = result_ch.out_valid;
                got.out_value = result_ch.out_value;
                got.halted    = result_ch.halted;
                got.div_zero  = result_ch.div_zero;
                sb.check_result(got);
                results_seen++;
                if (results_seen == STALL_AT && !stall_done) begin
                    hold_left  = STALL_CYCLES;
                    stall_done = 1'b1;
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                result_ch.ready <= 1'b0;
            end else if (results_seen >= QUIET_FIRST && results_seen < QUIET_LAST) begin
                result_ch.ready <= 1'b1;
            end else begin
                result_ch.ready <= ($urandom_range(0, 99) >= IDLE_PERCENT);
            end
        end
    end

    // Instruction side and end of run.
    initial begin
        sb = new();
        i_rst_n              <= 1'b0;
        instr_ch.valid       <= 1'b0;
        instr_ch.mode        <= OP_LDA;
        instr_ch.target_reg  <= '0;
        instr_ch.mem_base    <= '0;
        instr_ch.operand_num <= '0;
        instr_ch.indexed     <= 1'b0;
        instr_ch.in_value    <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // The block sweeps its memory after reset; the first handshake
        // simply waits that out.
        run_directed();
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            send_instr(random_instr(), !(n >= QUIET_FIRST && n < QUIET_LAST));
        end
        instr_ch.valid <= 1'b0;

        // Drain: wait for every predicted result, then let stray ones show.
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Executed %0d instructions (%0d directed), checked %0d results in %0d cycles",
                 sb.instr_count, directed_count, sb.result_count, cycle_count);
        $display("Saw %0d divides by zero, %0d taken jumps, %0d halts, %0d outputs, %0d errors",
                 sb.div_zero_count, sb.jumps_taken, sb.halt_count, sb.out_count, sb.errors);
        if (sb.errors == 0) begin
            $display("register_machine_executor test passed");
        end else begin
            $display("register_machine_executor test failed");
        end
        $finish;
    end

endmodule
